// ----- rtl/omb_pkg.sv -----
// ----------------------------------------------------------------------------
// omb_pkg
// Shared types and constants of the odd mask byte codec.
// ----------------------------------------------------------------------------
package omb_pkg;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // largest group the store can hold, and the width of a group position
  localparam int GROUP_MAX = 7;
  localparam int POS_W     = 3;

  localparam int QUEUE_DEPTH = 2;

  // command passed from the front to the back
  typedef struct packed {
    logic             enc;    // encode byte (1) or decoded result (0)
    logic             close;  // encode: this byte closes the group
    logic             odd;    // encode: input byte was odd
    logic [POS_W-1:0] pos;    // encode: slot of the byte in the group
    logic [7:0]       data;   // transformed byte
    logic             last;   // message ends with this byte
  } cmd_t;

endpackage

// ----- rtl/omb_front.sv -----
// ----------------------------------------------------------------------------
// omb_front
// Accepts input bytes, tracks group positions and turns each byte, except a
// decode mask byte, into a command for the back end.
// ----------------------------------------------------------------------------
module omb_front #(
  parameter int GROUP_SIZE = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_data_byte,
  input  logic          in_last_byte,
  input  logic          q_full,
  output logic          q_push,
  output omb_pkg::cmd_t q_cmd
);

  localparam logic [omb_pkg::POS_W-1:0] GS_LAST = omb_pkg::POS_W'(GROUP_SIZE - 1);
  localparam logic [omb_pkg::POS_W-1:0] GS_DEC  = omb_pkg::POS_W'(GROUP_SIZE);

  logic                      mode_r;
  logic [omb_pkg::POS_W-1:0] count_r, count_nxt;
  logic [omb_pkg::POS_W-1:0] dpos_r, dpos_nxt;
  logic [7:0]                dmask_r, dmask_nxt;
  logic                      accept;
  logic                      enc_close;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign enc_close = (count_r == GS_LAST) || in_last_byte;

  always_comb begin
    count_nxt   = count_r;
    dpos_nxt    = dpos_r;
    dmask_nxt   = dmask_r;
    q_push      = 1'b0;
    q_cmd       = '0;
    q_cmd.last  = in_last_byte;
    q_cmd.pos   = count_r;
    q_cmd.odd   = in_data_byte[0];
    q_cmd.close = enc_close;
    if (mode_r == omb_pkg::MODE_ENCODE) begin
      q_cmd.enc  = 1'b1;
      q_cmd.data = in_data_byte[0] ? in_data_byte : in_data_byte + 8'd1;
      q_push     = accept;
      if (accept) begin
        count_nxt = enc_close ? '0 : count_r + 1'b1;
      end
    end else begin
      q_cmd.enc  = 1'b0;
      q_cmd.data = dmask_r[dpos_r] ? in_data_byte : in_data_byte - 8'd1;
      // the byte at position zero is the mask and yields nothing
      q_push     = accept && (dpos_r != '0);
      if (accept) begin
        if (dpos_r == '0) begin
          dmask_nxt = in_data_byte;
        end
        if (in_last_byte) begin
          dpos_nxt  = '0;
          dmask_nxt = '0;
        end else begin
          dpos_nxt = (dpos_r == GS_DEC) ? '0 : dpos_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= omb_pkg::MODE_ENCODE;
      count_r <= '0;
      dpos_r  <= '0;
      dmask_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      count_r <= count_nxt;
      dpos_r  <= dpos_nxt;
      dmask_r <= dmask_nxt;
    end
  end

endmodule

// ----- rtl/omb_queue.sv -----
// ----------------------------------------------------------------------------
// omb_queue
// Small command FIFO between the front and the back end.
// ----------------------------------------------------------------------------
module omb_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  omb_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output omb_pkg::cmd_t pop_cmd
);

  localparam int PTR_W = $clog2(omb_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(omb_pkg::QUEUE_DEPTH + 1);

  omb_pkg::cmd_t    entry_r [omb_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full      = (count_r == CNT_W'(omb_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_cmd   = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(omb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(omb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/omb_back.sv -----
// ----------------------------------------------------------------------------
// omb_back
// Executes commands: collects encode groups and emits mask plus bytes,
// passes decoded bytes straight to the output register.
// ----------------------------------------------------------------------------
module omb_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_not_empty,
  input  omb_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_run_last,
  output logic          out_message_end
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic                      state_r, state_nxt;
  logic [omb_pkg::POS_W-1:0] idx_r, idx_nxt;
  logic [omb_pkg::POS_W-1:0] nlast_r, nlast_nxt;
  logic                      last_r, last_nxt;
  logic [7:0]                mask_r, mask_nxt;
  logic [7:0]                store_r [omb_pkg::GROUP_MAX];
  logic [omb_pkg::POS_W-1:0] rd_idx;
  logic                      st_we;
  logic                      out_free;
  logic                      load;
  logic [7:0]                ld_byte;
  logic                      ld_run, ld_end;
  logic                      out_valid_r;
  logic [7:0]                out_byte_r;
  logic                      out_run_last_r, out_message_end_r;

  assign out_free = !out_valid_r || out_ready;
  assign rd_idx   = idx_r - 1'b1;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    nlast_nxt = nlast_r;
    last_nxt  = last_r;
    mask_nxt  = mask_r;
    q_pop     = 1'b0;
    st_we     = 1'b0;
    load      = 1'b0;
    ld_byte   = q_cmd.data;
    ld_run    = 1'b1;
    ld_end    = q_cmd.last;
    case (state_r)
      ST_IDLE: begin
        if (q_not_empty) begin
          if (q_cmd.enc) begin
            q_pop    = 1'b1;
            st_we    = 1'b1;
            mask_nxt = mask_r | (8'(q_cmd.odd) << (q_cmd.pos + 1'b1));
            if (q_cmd.close) begin
              state_nxt = ST_EMIT;
              idx_nxt   = '0;
              nlast_nxt = q_cmd.pos + 1'b1;
              last_nxt  = q_cmd.last;
            end
          end else if (out_free) begin
            q_pop = 1'b1;
            load  = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        // slot zero is the mask, slot k is group byte k-1
        ld_byte = (idx_r == '0) ? mask_r : store_r[rd_idx];
        ld_run  = (idx_r == nlast_r);
        ld_end  = (idx_r == nlast_r) && last_r;
        if (out_free) begin
          load = 1'b1;
          if (idx_r == '0) begin
            mask_nxt = 8'd1;
          end
          if (idx_r == nlast_r) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      store_r[q_cmd.pos] <= q_cmd.data;
    end
    if (load) begin
      out_byte_r        <= ld_byte;
      out_run_last_r    <= ld_run;
      out_message_end_r <= ld_end;
    end
    idx_r   <= idx_nxt;
    nlast_r <= nlast_nxt;
    last_r  <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mask_r      <= 8'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mask_r  <= mask_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_run_last    = out_run_last_r;
  assign out_message_end = out_message_end_r;

endmodule

// ----- rtl/odd_mask_byte_codec_top.sv -----
// ----------------------------------------------------------------------------
// odd_mask_byte_codec_top
// Byte-stream codec: encode adds a mask byte before each group of odd/even
// marked bytes, decode strips masks and restores the bytes.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_wr_en/cfg_wr_data set the mode (0 encode, 1 decode); write it only
//   while the block is idle.
//   Input bytes arrive on in_valid/in_ready with in_last_byte marking the end
//   of a message; results leave on out_valid/out_ready with out_run_last on
//   the final byte of an encoded group and on every decoded byte, and
//   out_message_end on the final result of a message.
//   Decode: one result per data byte, registered through the command queue
//   and the output register, one byte per cycle sustained while out_ready is high.
//   Encode: the back end collects a group's bytes in the group store, then
//   emits mask and bytes, one per cycle while out_ready is high; the mask is
//   loaded into the output register after the closing byte has passed the
//   command queue and the back end has entered its emit state. While the
//   group store is being read out, the back end takes no new commands.
//   A two-entry command queue lets the input side keep taking bytes while
//   the output is stalled; when it fills, in_ready drops.
//   Reset (rst_n low, synchronous) selects encode and clears group state.
// ----------------------------------------------------------------------------
module odd_mask_byte_codec_top #(
  parameter int GROUP_SIZE = 7
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_message_end
);

  logic          q_full, q_push, q_pop, q_not_empty;
  omb_pkg::cmd_t push_cmd, pop_cmd;

  omb_front #(
    .GROUP_SIZE(GROUP_SIZE)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  omb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_cmd   (pop_cmd)
  );

  omb_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (q_not_empty),
    .q_cmd           (pop_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_run_last    (out_run_last),
    .out_message_end (out_message_end)
  );

endmodule

// ----- rtl/omb_checker.sv -----
// ----------------------------------------------------------------------------
// omb_checker
// Port-level checks of the odd mask byte codec, bound to the top level.
// ----------------------------------------------------------------------------
module omb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_run_last,
  input logic       out_message_end
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte)
      && $stable(out_run_last) && $stable(out_message_end))
    else $error("result changed while stalled");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_message_end |-> out_run_last)
    else $error("message end without run last");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind odd_mask_byte_codec_top omb_checker u_omb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_byte        (out_byte),
  .out_run_last    (out_run_last),
  .out_message_end (out_message_end)
);
